@@ rtl/core/mh_pkg.sv @@
// Shared types, constants and helper functions of the magnetometer heading block.
`timescale 1ns / 1ps
`default_nettype none

package mh_pkg;

	// Width of the CORDIC x/y datapath: 16-bit reading, 8 scaling bits, gain headroom.
	localparam int CORDIC_W = 26;

	// Pre-scaling shift applied to the magnitudes before the first iteration.
	localparam int PRESCALE_SHIFT = 8;

	// Arctangent table, atan(2^-i) in degrees with 24 fraction bits.
	localparam int ATAN_TABLE_LEN  = 24;
	localparam int ATAN_TABLE_FRAC = 24;
	localparam longint ATAN_DEG_Q24 [ATAN_TABLE_LEN] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	// Full circle in whole degrees.
	localparam logic [8:0] FULL_CIRCLE_DEG = 9'd360;

	// One input transfer: a raw X/Y field reading.
	typedef struct packed {
		logic signed [15:0] field_x;
		logic signed [15:0] field_y;
	} sample_t;

	// One result transfer: heading and sixteen-point bearing.
	typedef struct packed {
		logic [8:0] azimuth_degrees;
		logic [3:0] compass_point;
	} heading_t;

	// Quadrant and axis information that rides along the iteration pipeline.
	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic x_zero;
		logic y_zero;
	} quad_t;

	// Bearing index: round(a / 22.5), done as compares of 20a + 225 against 450k.
	// A value that rounds to sixteen wraps to north.
	function automatic logic [3:0] compass_point_of(input logic [8:0] a);
		logic [12:0] n;
		logic [3:0]  cnt;
		n   = 13'(a) * 13'd20 + 13'd225;
		cnt = '0;
		for (int k = 1; k < 16; k++) begin
			if (n >= 13'(450 * k)) begin
				cnt = cnt + 4'd1;
			end
		end
		if (n >= 13'd7200) begin
			cnt = '0;
		end
		return cnt;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/mh_cordic_stage.sv @@
// One registered vectoring CORDIC iteration with a fixed shift and angle step.
`timescale 1ns / 1ps
`default_nettype none

module mh_cordic_stage
	import mh_pkg::*;
#(
	parameter int STAGE     = 0,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            valid_in,
	input  wire quad_t                           quad_in,
	input  wire logic signed [CORDIC_W-1:0]      x_in,
	input  wire logic signed [CORDIC_W-1:0]      y_in,
	input  wire logic signed [FRAC_BITS+8:0]     z_in,
	output logic                                 valid_out,
	output quad_t                                quad_out,
	output logic signed [CORDIC_W-1:0]           x_out,
	output logic signed [CORDIC_W-1:0]           y_out,
	output logic signed [FRAC_BITS+8:0]          z_out
);

	localparam int     ZW       = FRAC_BITS + 9;
	localparam int     SH       = ATAN_TABLE_FRAC - FRAC_BITS;
	localparam longint STEP_VAL = (ATAN_DEG_Q24[STAGE] + (longint'(1) << (SH - 1))) >> SH;
	localparam logic signed [ZW-1:0] STEP = ZW'(STEP_VAL);

	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;
	logic signed [CORDIC_W-1:0] x_nxt;
	logic signed [CORDIC_W-1:0] y_nxt;
	logic signed [ZW-1:0]       z_nxt;

	// Rotate toward the x axis; the direction follows the sign of y.
	always_comb begin
		dx = y_in >>> STAGE;
		dy = x_in >>> STAGE;
		if (!y_in[CORDIC_W-1]) begin
			x_nxt = x_in + dx;
			y_nxt = y_in - dy;
			z_nxt = z_in + STEP;
		end else begin
			x_nxt = x_in - dx;
			y_nxt = y_in + dy;
			z_nxt = z_in - STEP;
		end
	end

	// Valid flag is cleared by reset; the datapath needs none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		quad_out <= quad_in;
		x_out    <= x_nxt;
		y_out    <= y_nxt;
		z_out    <= z_nxt;
	end

endmodule

`default_nettype wire

@@ rtl/core/magnetometer_heading.sv @@
// Top level of the magnetometer heading block: input register, CORDIC pipeline, result stage.
`timescale 1ns / 1ps
`default_nettype none

// Computes a compass heading from one signed X/Y magnetometer reading.
// Input channel: a reading is transferred at a clock edge with start high and
// busy low. busy is always low, so a new reading may be transferred every cycle.
// Result channel: done is high for exactly one cycle with the heading on result;
// the result is transferred at the edge that ends that cycle. Results come out
// in input order, one per reading.
// The path from start to result runs through one input register, one pipeline
// register per CORDIC iteration and one result register. Throughput is
// one reading per cycle, set by the fully pipelined iteration chain.
// rotate_heading is written through cfg_we/cfg_wdata; set it while no reading
// is in flight. Reset clears the pipeline valid flags, done and rotate_heading.
// The receiver cannot stall, so nothing is ever held back.
module magnetometer_heading
	import mh_pkg::*;
#(
	parameter int CORDIC_ITERATIONS   = 16,
	parameter int ANGLE_FRACTION_BITS = 8
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire sample_t sample,
	input  wire logic    cfg_we,
	input  wire logic    cfg_wdata,
	output logic         done,
	output heading_t     result
);

	localparam int ZW = ANGLE_FRACTION_BITS + 9;
	localparam logic signed [ZW-1:0] FULL90  = ZW'(90 * (longint'(1) << ANGLE_FRACTION_BITS));
	localparam logic signed [ZW-1:0] FULL180 = ZW'(180 * (longint'(1) << ANGLE_FRACTION_BITS));

	logic rotate_heading_q;

	logic                  valid_s1;
	quad_t                 quad_s1;
	logic signed [16:0]    fx;
	logic signed [16:0]    fy;
	logic signed [16:0]    ax;
	logic signed [16:0]    ay;
	logic signed [CORDIC_W-1:0] x_s1;
	logic signed [CORDIC_W-1:0] y_s1;

	logic                       vc [0:CORDIC_ITERATIONS];
	quad_t                      qc [0:CORDIC_ITERATIONS];
	logic signed [CORDIC_W-1:0] xc [0:CORDIC_ITERATIONS];
	logic signed [CORDIC_W-1:0] yc [0:CORDIC_ITERATIONS];
	logic signed [ZW-1:0]       zc [0:CORDIC_ITERATIONS];

	logic signed [ZW-1:0] z_clamp;
	logic signed [ZW-1:0] theta;
	logic [7:0]           deg;
	logic [8:0]           angle;
	logic [8:0]           azimuth;

	logic     done_q;
	heading_t result_q;

	// The pipeline takes a reading every cycle.
	assign busy = 1'b0;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_heading_q <= 1'b0;
		end else if (cfg_we) begin
			rotate_heading_q <= cfg_wdata;
		end
	end

	// Magnitudes of the reading.
	always_comb begin
		fx = 17'(sample.field_x);
		fy = 17'(sample.field_y);
		ax = fx[16] ? -fx : fx;
		ay = fy[16] ? -fy : fy;
	end

	// Input register: scaled magnitudes plus quadrant and axis flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		quad_s1.x_neg  <= fx[16];
		quad_s1.y_neg  <= fy[16];
		quad_s1.x_zero <= (fx == '0);
		quad_s1.y_zero <= (fy == '0);
		x_s1 <= CORDIC_W'(ax) <<< PRESCALE_SHIFT;
		y_s1 <= CORDIC_W'(ay) <<< PRESCALE_SHIFT;
	end

	assign vc[0] = valid_s1;
	assign qc[0] = quad_s1;
	assign xc[0] = x_s1;
	assign yc[0] = y_s1;
	assign zc[0] = '0;

	// One registered stage per CORDIC iteration.
	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
		mh_cordic_stage #(
			.STAGE     (i),
			.FRAC_BITS (ANGLE_FRACTION_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vc[i]),
			.quad_in   (qc[i]),
			.x_in      (xc[i]),
			.y_in      (yc[i]),
			.z_in      (zc[i]),
			.valid_out (vc[i+1]),
			.quad_out  (qc[i+1]),
			.x_out     (xc[i+1]),
			.y_out     (yc[i+1]),
			.z_out     (zc[i+1])
		);
	end

	// Clamp to the first quadrant, apply axis cases, map to the full circle, then mirror if rotate_heading is set.
	always_comb begin
		z_clamp = zc[CORDIC_ITERATIONS];
		if (z_clamp < 0) begin
			z_clamp = '0;
		end else if (z_clamp > FULL90) begin
			z_clamp = FULL90;
		end

		if (qc[CORDIC_ITERATIONS].y_zero) begin
			theta = '0;
		end else if (qc[CORDIC_ITERATIONS].x_zero) begin
			theta = FULL90;
		end else begin
			theta = z_clamp;
		end

		if (qc[CORDIC_ITERATIONS].x_neg) begin
			theta = FULL180 - theta;
		end

		deg = 8'(theta >>> ANGLE_FRACTION_BITS);

		if (!qc[CORDIC_ITERATIONS].y_neg || deg == '0) begin
			angle = 9'(deg);
		end else begin
			angle = FULL_CIRCLE_DEG - 9'(deg);
		end

		azimuth = rotate_heading_q ? (FULL_CIRCLE_DEG - angle) : angle;
	end

	// Result register and done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vc[CORDIC_ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		result_q.azimuth_degrees <= azimuth;
		result_q.compass_point   <= compass_point_of(azimuth);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
